>>> hdl/msc_pkg.sv
package msc_pkg;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      REG_OFFSET_X   = 3'd0,
      REG_OFFSET_Y   = 3'd1,
      REG_OFFSET_Z   = 3'd2,
      REG_INV_GAIN_X = 3'd3,
      REG_INV_GAIN_Y = 3'd4,
      REG_INV_GAIN_Z = 3'd5,
      REG_RES_SELECT = 3'd6
   } reg_index_type;

   localparam int NUM_AXES    = 3;
   localparam int RAW_W       = 16;
   localparam int OFFSET_W    = 17;
   localparam int GAIN_W      = 16;
   localparam int RES_SEL_W   = 3;
   localparam int FIELD_W     = 32;
   localparam int DIFF_W      = 21;  // raw*16 - offset
   localparam int PROD1_W     = 38;  // diff * inv_gain, 2^-18 count
   localparam int STAGE1_SHIFT = 18;
   localparam int COUNT_W     = 16;
   localparam int RES_W       = 19;  // 2^-16 mGa/LSB, unsigned
   localparam int TEMP_W      = 36;  // centred field, 2^-16 mGa
   localparam int SPLIT       = 18;  // low slice width for the matrix products
   localparam int COEF_W      = 21;
   localparam int PPH_W       = 39;
   localparam int PPL_W       = 40;
   localparam int PROD_W      = 57;
   localparam int ACC_W       = 59;
   localparam int OUT_SHIFT   = 28;

   typedef logic signed [COEF_W-1:0] soft_coef_type;
   typedef logic signed [24:0]       hard_centre_type;

   localparam hard_centre_type HARD_CENTRE [NUM_AXES] = '{
      -25'sd14304084, -25'sd4003293, -25'sd1077949
   };

   // symmetric soft-iron matrix, 2^-20
   localparam soft_coef_type SOFT_MATRIX [NUM_AXES][NUM_AXES] = '{
      '{21'sd871525,  21'sd5133,    21'sd45888},
      '{21'sd5133,    21'sd873477, -21'sd314},
      '{21'sd45888,  -21'sd314,     21'sd1036677}
   };

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd1 <<< (OUT_SHIFT - 1));

   // resolution in 2^-16 mGa per LSB
   function automatic logic [RES_W-1:0] res_lookup(input logic [RES_SEL_W-1:0] sel);
      logic [RES_W-1:0] r;
      unique case (sel)
         3'd0: r = 19'd47841;
         3'd1: r = 19'd60293;
         3'd2: r = 19'd79954;
         3'd3: r = 19'd99615;
         3'd4: r = 19'd148767;
         3'd5: r = 19'd167772;
         3'd6: r = 19'd198574;
         default: r = 19'd285082;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/magnetometer_sample_compensation.sv
// channel | ports      | direction | contents
// req     | req_t*     | in        | raw_x, raw_y, raw_z (one sample)
// rsp     | rsp_t*     | out       | field_x, field_y, field_z (1/256 mGa)
// csr     | csr_*      | in        | register index, write data
//
// Eight register stages; one sample per cycle sustained while the output is not stalled.
// The stages cover the two multiplier passes (gain, resolution) and the
// split 36x21 soft-iron products, each followed by its own register.
// Synchronous reset clears stage valids and loads register defaults.
// A stalled output holds; a stage takes a new item whenever it is empty
// or its successor moves, so bubbles are squeezed out under backpressure.
module magnetometer_sample_compensation (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // raw_x [15:0], raw_y [31:16], raw_z [47:32]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // field_x [31:0], field_y [63:32], field_z [95:64]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_addr,
   input  logic [16:0]  csr_wdata
);

   localparam int NST = 8;
   localparam int NA  = msc_pkg::NUM_AXES;

   // configuration registers
   logic signed [msc_pkg::OFFSET_W-1:0]  offset_ff [NA];
   logic [msc_pkg::GAIN_W-1:0]           inv_gain_ff [NA];
   logic [msc_pkg::RES_SEL_W-1:0]        res_sel_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NA; i++) begin
            offset_ff[i]   <= '0;
            inv_gain_ff[i] <= msc_pkg::GAIN_W'(16384);
         end
         res_sel_ff <= '0;
      end else if (csr_valid) begin
         unique case (msc_pkg::reg_index_type'(csr_addr))
            msc_pkg::REG_OFFSET_X:   offset_ff[0]   <= csr_wdata;
            msc_pkg::REG_OFFSET_Y:   offset_ff[1]   <= csr_wdata;
            msc_pkg::REG_OFFSET_Z:   offset_ff[2]   <= csr_wdata;
            msc_pkg::REG_INV_GAIN_X: inv_gain_ff[0] <= csr_wdata[15:0];
            msc_pkg::REG_INV_GAIN_Y: inv_gain_ff[1] <= csr_wdata[15:0];
            msc_pkg::REG_INV_GAIN_Z: inv_gain_ff[2] <= csr_wdata[15:0];
            msc_pkg::REG_RES_SELECT: res_sel_ff     <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // stage valids and per-stage load enables
   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;
   logic [NST-1:0] en;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_tready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_tvalid : v_ff[0];
      for (int k = 1; k < NST; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NST-1];

   // stage payloads
   logic signed [msc_pkg::DIFF_W-1:0]  diff_ff [NA];
   logic [msc_pkg::GAIN_W-1:0]         gain_ff [NA];
   logic signed [msc_pkg::PROD1_W-1:0] p_ff [NA];
   logic signed [msc_pkg::COUNT_W-1:0] count_ff [NA];
   logic signed [msc_pkg::TEMP_W-1:0]  scaled_ff [NA];
   logic signed [msc_pkg::TEMP_W-1:0]  temp_ff [NA];
   logic signed [msc_pkg::PPH_W-1:0]   pph_ff [NA][NA];
   logic signed [msc_pkg::PPL_W-1:0]   ppl_ff [NA][NA];
   logic signed [msc_pkg::PROD_W-1:0]  prod_ff [NA][NA];
   logic signed [msc_pkg::ACC_W-1:0]   acc_ff [NA];

   logic signed [msc_pkg::DIFF_W-1:0]  diff_in [NA];
   logic signed [msc_pkg::PROD1_W-1:0] p_in [NA];
   logic signed [msc_pkg::COUNT_W-1:0] count_in [NA];
   logic signed [msc_pkg::TEMP_W-1:0]  scaled_in [NA];
   logic signed [msc_pkg::TEMP_W-1:0]  temp_in [NA];
   logic signed [msc_pkg::PPH_W-1:0]   pph_in [NA][NA];
   logic signed [msc_pkg::PPL_W-1:0]   ppl_in [NA][NA];
   logic signed [msc_pkg::PROD_W-1:0]  prod_in [NA][NA];
   logic signed [msc_pkg::ACC_W-1:0]   acc_in [NA];
   logic [msc_pkg::RES_W-1:0]          res_val;

   assign res_val = msc_pkg::res_lookup(res_sel_ff);

   always_comb begin
      logic signed [msc_pkg::RAW_W-1:0]   raw;
      logic signed [msc_pkg::PROD1_W-1:0] biased;
      logic signed [msc_pkg::PROD1_W-1:0] shifted;
      logic signed [msc_pkg::SPLIT:0]     lo;
      logic signed [msc_pkg::TEMP_W-msc_pkg::SPLIT-1:0] hi;
      for (int i = 0; i < NA; i++) begin
         // stage 0: scale to 1/16 count, remove offset
         raw = req_tdata[msc_pkg::RAW_W*i +: msc_pkg::RAW_W];
         diff_in[i] = $signed({raw[15], raw, 4'b0000})
                      - msc_pkg::DIFF_W'(offset_ff[i]);
         // stage 1: reciprocal gain
         p_in[i] = diff_ff[i] * $signed({1'b0, gain_ff[i]});
         // stage 2: truncate toward zero, saturate to int16
         biased = p_ff[i] + (p_ff[i][msc_pkg::PROD1_W-1]
                  ? msc_pkg::PROD1_W'((64'sd1 <<< msc_pkg::STAGE1_SHIFT) - 64'sd1)
                  : msc_pkg::PROD1_W'(0));
         shifted = biased >>> msc_pkg::STAGE1_SHIFT;
         if (shifted > msc_pkg::PROD1_W'(32767)) begin
            count_in[i] = 16'sh7FFF;
         end else if (shifted < -msc_pkg::PROD1_W'(32768)) begin
            count_in[i] = -16'sh8000;
         end else begin
            count_in[i] = shifted[msc_pkg::COUNT_W-1:0];
         end
         // stage 3: resolution
         scaled_in[i] = count_ff[i] * $signed({1'b0, res_val});
         // stage 4: hard-iron centre
         temp_in[i] = scaled_ff[i] - msc_pkg::TEMP_W'(msc_pkg::HARD_CENTRE[i]);
      end
      // stage 5: soft-iron products, centred value split in two slices
      for (int j = 0; j < NA; j++) begin
         hi = temp_ff[j][msc_pkg::TEMP_W-1:msc_pkg::SPLIT];
         lo = $signed({1'b0, temp_ff[j][msc_pkg::SPLIT-1:0]});
         for (int i = 0; i < NA; i++) begin
            pph_in[i][j] = hi * msc_pkg::SOFT_MATRIX[i][j];
            ppl_in[i][j] = lo * msc_pkg::SOFT_MATRIX[i][j];
         end
      end
      for (int i = 0; i < NA; i++) begin
         // stage 6: rejoin slices
         for (int j = 0; j < NA; j++) begin
            prod_in[i][j] = (msc_pkg::PROD_W'(pph_ff[i][j]) <<< msc_pkg::SPLIT)
                            + msc_pkg::PROD_W'(ppl_ff[i][j]);
         end
         // stage 7: row sum with round-half-up bias
         acc_in[i] = msc_pkg::ACC_W'(prod_ff[i][0]) + msc_pkg::ACC_W'(prod_ff[i][1])
                     + msc_pkg::ACC_W'(prod_ff[i][2]) + msc_pkg::ROUND_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         if (en[0]) begin
            diff_ff[i] <= diff_in[i];
            gain_ff[i] <= inv_gain_ff[i];
         end
         if (en[1]) p_ff[i] <= p_in[i];
         if (en[2]) count_ff[i] <= count_in[i];
         if (en[3]) scaled_ff[i] <= scaled_in[i];
         if (en[4]) temp_ff[i] <= temp_in[i];
         for (int j = 0; j < NA; j++) begin
            if (en[5]) begin
               pph_ff[i][j] <= pph_in[i][j];
               ppl_ff[i][j] <= ppl_in[i][j];
            end
            if (en[6]) prod_ff[i][j] <= prod_in[i][j];
         end
         if (en[7]) acc_ff[i] <= acc_in[i];
      end
   end

   // accumulator bounds keep the shifted sum inside int32, so no clamp is needed
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         rsp_tdata[msc_pkg::FIELD_W*i +: msc_pkg::FIELD_W] =
            msc_pkg::FIELD_W'(acc_ff[i] >>> msc_pkg::OUT_SHIFT);
      end
   end

`ifndef SYNTH
   a_reset_clears: assert property (@(posedge clock) reset |=> v_ff == '0)
      else $error("stage valids not cleared by reset");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0])
      else $error("accepted sample missing from first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v_ff[6] && !en[6] |=> v_ff[6] && $stable(prod_ff[0][0]) && $stable(prod_ff[2][2]))
      else $error("stalled product stage changed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      v_ff[NST-1] && !rsp_tready |-> !en[NST-1])
      else $error("waiting result would be overwritten");
`endif

endmodule
